// File: rtl/lss_pkg.sv
// lss_pkg: shared constants, codes and types of the lifo stack with search
// no dependencies; compiled first
`default_nettype none

package lss_pkg;

   // stack geometry and field widths
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int POS_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int REQ_W      = 3;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH  = 3'd0,
      REQ_POP   = 3'd1,
      REQ_FIND  = 3'd2,
      REQ_READ  = 3'd3,
      REQ_CLEAR = 3'd4
   } req_code_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // shift control handed to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

   // one result transaction
   typedef struct packed {
      logic [DATA_WIDTH-1:0] top_word;
      logic [CNT_W-1:0]      stack_size;
      logic                  is_empty;
      logic                  found;
      logic [POS_W-1:0]      found_position;
      logic [DATA_WIDTH-1:0] read_word;
      logic                  error;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/lss_ifs.sv
// lss_req_if and lss_rsp_if: valid/ready channels of the lifo stack with search
// depends on lss_pkg
`default_nettype none

interface lss_req_if;
   import lss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_W-1:0]      req_type;
   logic [DATA_WIDTH-1:0] data_value;
   logic [POS_W-1:0]      position;

   modport source (output valid, output req_type, output data_value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input data_value, input position,
                   output ready);
endinterface

interface lss_rsp_if;
   import lss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] top_word;
   logic [CNT_W-1:0]      stack_size;
   logic                  is_empty;
   logic                  found;
   logic [POS_W-1:0]      found_position;
   logic [DATA_WIDTH-1:0] read_word;
   logic                  error;

   modport source (output valid, output top_word, output stack_size, output is_empty,
                   output found, output found_position, output read_word, output error,
                   input ready);
   modport sink   (input valid, input top_word, input stack_size, input is_empty,
                   input found, input found_position, input read_word, input error,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/lifo_stack_with_search_top.sv
// lifo_stack_with_search_top: top level, request sequencer, row of stack cells and
// result register; depends on lss_pkg, lss_ifs, lss_cell and lss_find
//
// usage
//   requests arrive on req_bus (valid/ready): req_type selects push, pop, find,
//   read at a position from the top, or clear; data_value is the word to push or
//   the key to find. every request gives one result transaction on rsp_bus with
//   the top word, size, empty flag, find outcome, read word and error flag.
//   the stack is a row of cells with cell 0 on top; a push shifts every cell
//   down one place and a pop shifts them up, all in the cycle of acceptance.
//   the execute state runs the per-cell compare, the priority encode and the
//   indexed read into the result register; the two-state sequencer takes a new
//   request only in the idle state, once the last result is registered.
//   a stalled rsp_bus holds its result; one more request is accepted meanwhile
//   and waits in the execute state until the result register is free.
//   reset: synchronous, clears the word count, sequencer and result valid;
//   the cells themselves are not cleared and are never read above the count.
`default_nettype none

module lifo_stack_with_search_top (
   input wire logic clock,
   input wire logic reset,
   lss_req_if.sink   req_bus,
   lss_rsp_if.source rsp_bus
);
   import lss_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   req_code_type          op_ff, op_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   cell_ctl_type          ctl;
   logic                  accept;
   req_code_type          req_op;
   logic [DATA_WIDTH-1:0] cell_words [DEPTH];
   logic [DEPTH-1:0]      cell_match;
   rsp_type               result;

   // requests are taken only in the idle state
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign req_op = req_code_type'(req_bus.req_type);
   assign accept = req_bus.valid && req_bus.ready;

   // sequencer: decode on acceptance, build the result in the execute state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               key_in   = req_bus.data_value;
               pos_in   = req_bus.position;
               err_in   = 1'b0;
               state_in = ST_EXEC;
               case (req_op)
                  REQ_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        err_in = 1'b1;
                     end else begin
                        ctl.push = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        err_in = 1'b1;
                     end else begin
                        ctl.pop  = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  REQ_READ: begin
                     err_in = ({1'b0, req_bus.position} >= count_ff);
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   // request payload and result register
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // row of cells, cell 0 on top
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] above;
      logic [DATA_WIDTH-1:0] below;

      if (i == 0) begin : g_top
         assign above = req_bus.data_value;
      end else begin : g_inner
         assign above = cell_words[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign below = cell_words[i];
      end else begin : g_upper
         assign below = cell_words[i+1];
      end

      lss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .word_above (above),
         .word_below (below),
         .key        (key_ff),
         .word       (cell_words[i]),
         .match      (cell_match[i])
      );
   end

   // search, read and result assembly
   lss_find u_find (
      .cell_words (cell_words),
      .cell_match (cell_match),
      .count      (count_ff),
      .op         (op_ff),
      .pos        (pos_ff),
      .err        (err_ff),
      .result     (result)
   );

   // result channel
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.top_word       = rsp_ff.top_word;
   assign rsp_bus.stack_size     = rsp_ff.stack_size;
   assign rsp_bus.is_empty       = rsp_ff.is_empty;
   assign rsp_bus.found          = rsp_ff.found;
   assign rsp_bus.found_position = rsp_ff.found_position;
   assign rsp_bus.read_word      = rsp_ff.read_word;
   assign rsp_bus.error          = rsp_ff.error;

endmodule

`default_nettype wire

// File: rtl/lss_cell.sv
// lss_cell: one stack cell; shifts down on push and up on pop, compares against the key
// depends on lss_pkg
`default_nettype none

module lss_cell (
   input  wire logic                          clock,
   input  wire lss_pkg::cell_ctl_type         ctl,
   input  wire logic [lss_pkg::DATA_WIDTH-1:0] word_above,
   input  wire logic [lss_pkg::DATA_WIDTH-1:0] word_below,
   input  wire logic [lss_pkg::DATA_WIDTH-1:0] key,
   output logic      [lss_pkg::DATA_WIDTH-1:0] word,
   output logic                               match
);
   import lss_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // take the neighbour's word on a shift, otherwise hold
   always_comb begin
      word_in = word_ff;
      if (ctl.push) begin
         word_in = word_above;
      end else if (ctl.pop) begin
         word_in = word_below;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // per-cell comparator for find
   assign word  = word_ff;
   assign match = (word_ff == key);

endmodule

`default_nettype wire

// File: rtl/lss_find.sv
// lss_find: priority encode of cell matches, indexed read and result assembly
// depends on lss_pkg
`default_nettype none

module lss_find (
   input  wire logic [lss_pkg::DATA_WIDTH-1:0] cell_words [lss_pkg::DEPTH],
   input  wire logic [lss_pkg::DEPTH-1:0]      cell_match,
   input  wire logic [lss_pkg::CNT_W-1:0]      count,
   input  wire lss_pkg::req_code_type          op,
   input  wire logic [lss_pkg::POS_W-1:0]      pos,
   input  wire logic                          err,
   output lss_pkg::rsp_type                   result
);
   import lss_pkg::*;

   logic [DEPTH-1:0] hit;
   logic             any_hit;
   logic [POS_W-1:0] hit_pos;

   // only cells holding a stored word take part
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = cell_match[i] && (CNT_W'(i) < count);
      end
   end

   // first hit counted from the top (cell 0)
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_pos = POS_W'(i);
         end
      end
   end

   assign any_hit = |hit;

   // assemble the result transaction
   always_comb begin
      result                = '0;
      result.stack_size     = count;
      result.is_empty       = (count == '0);
      result.top_word       = (count == '0) ? '0 : cell_words[0];
      result.error          = err;
      if (op == REQ_FIND && any_hit) begin
         result.found          = 1'b1;
         result.found_position = hit_pos;
      end
      if (op == REQ_READ && !err) begin
         result.read_word = cell_words[pos];
      end
   end

endmodule

`default_nettype wire
